// ===== sv/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: request types, fixed-point widths,
// reciprocal constants and sector codes. Depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

  // Fixed-point formats.
  localparam int HUE_FRACTION_BITS = 6;
  localparam int SAT_FRACTION_BITS = 8;

  // Field widths of the request and result.
  localparam int HUE_W = 15;
  localparam int SAT_W = 9;
  localparam int LVL_W = 8;
  localparam int GRB_W = 24;

  // Hue sector geometry: one sector is 60 degrees, that is 15 << (HFB + 2).
  localparam int NUM_SECTORS = 6;
  localparam int SECTOR_SIZE = 60 << HUE_FRACTION_BITS;
  localparam int SEC_W       = HUE_FRACTION_BITS + 6;
  localparam int SAT_ONE     = 1 << SAT_FRACTION_BITS;
  localparam int OMS_W       = SAT_FRACTION_BITS + 1;

  // Hue bits above the power-of-two part of the sector size.
  localparam int HUE_HI_LSB = HUE_FRACTION_BITS + 2;
  localparam int QS_W       = HUE_W - HUE_HI_LSB;

  // Denominator of q and t: sector size times saturation one.
  localparam int DEN_W = SEC_W + SAT_FRACTION_BITS;
  localparam logic [DEN_W-1:0] DEN = DEN_W'(SECTOR_SIZE) << SAT_FRACTION_BITS;

  // Scaled products and the shift that leaves only a divide by 15.
  localparam int PROD_W    = DEN_W + LVL_W;
  localparam int DIV_SHIFT = HUE_HI_LSB + SAT_FRACTION_BITS;
  localparam int SH_W      = PROD_W - DIV_SHIFT;

  // Reciprocals: x / 15 = (x * RECIP15) >> 20 for x below 8192,
  // x / 6 = (x * RECIP6) >> 18 for x below 65536.
  localparam int RECIP15       = 69906;
  localparam int RECIP15_SHIFT = 20;
  localparam int RECIP6        = 43691;
  localparam int RECIP6_SHIFT  = 18;

  // Sector codes, named after the hue range each one covers.
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

  // Input request.
  typedef struct packed {
    logic [HUE_W-1:0] hue_angle;
    logic [SAT_W-1:0] sat_level;
    logic [LVL_W-1:0] brightness;
  } in_t;

  // Output result.
  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic [GRB_W-1:0] packed_grb;
  } out_t;

  // Intermediate values handed from the front to the back pipeline.
  typedef struct packed {
    logic [2:0]       sector;
    logic [LVL_W-1:0] v;
    logic [LVL_W-1:0] p;
    logic [DEN_W-1:0] q_num;
    logic [DEN_W-1:0] t_num;
  } mid_t;

endpackage

`default_nettype wire

// ===== sv/hsv2rgb_front.sv =====
// Front pipeline of the HSV to RGB converter: sector split, p level and
// the numerators of q and t, three register stages. Uses hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hsv2rgb_pkg::in_t   in_data_i,
  output logic                    mid_valid_o,
  input  wire logic               mid_ready_i,
  output hsv2rgb_pkg::mid_t       mid_data_o
);
  import hsv2rgb_pkg::*;

  // Stage 1: clamped saturation and raw sector count.
  logic                  s1_valid_q;
  logic [HUE_W-1:0]      s1_hue_q;
  logic [SAT_W-1:0]      s1_sat_q;
  logic [LVL_W-1:0]      s1_v_q;
  logic [QS_W-1:0]       s1_qsec_q;
  // Stage 2: remainder, sector count over six and p.
  logic                  s2_valid_q;
  logic [SEC_W-1:0]      s2_r_q;
  logic [QS_W-1:0]       s2_qsec_q;
  logic [QS_W-1:0]       s2_q6_q;
  logic [SAT_W-1:0]      s2_sat_q;
  logic [LVL_W-1:0]      s2_v_q;
  logic [LVL_W-1:0]      s2_p_q;
  // Stage 3: handed to the back pipeline.
  logic                  s3_valid_q;
  mid_t                  s3_data_q;

  logic s1_ready, s2_ready, s3_ready;

  // Per-stage ready lets bubbles close up while the output stalls.
  assign s3_ready   = !s3_valid_q || mid_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Saturation clamp and sector count: hue / (15 << HUE_HI_LSB).
  logic                       sat_over;
  logic [SAT_W-1:0]           sat_clamped;
  logic [QS_W-1:0]            hue_hi;
  logic [QS_W+RECIP15_SHIFT-1:0] qsec_prod;

  assign sat_over    = (32'(in_data_i.sat_level) > 32'(SAT_ONE));
  assign sat_clamped = sat_over ? SAT_W'(SAT_ONE) : in_data_i.sat_level;
  assign hue_hi      = in_data_i.hue_angle[HUE_W-1:HUE_HI_LSB];
  assign qsec_prod   = (QS_W+RECIP15_SHIFT)'(hue_hi) * (QS_W+RECIP15_SHIFT)'(RECIP15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_hue_q  <= in_data_i.hue_angle;
      s1_sat_q  <= sat_clamped;
      s1_v_q    <= in_data_i.brightness;
      s1_qsec_q <= qsec_prod[RECIP15_SHIFT +: QS_W];
    end
  end

  // Remainder within the sector, sector count over six, and p.
  logic [31:0]                  r_full;
  logic [QS_W+RECIP6_SHIFT-1:0] q6_prod;
  logic [OMS_W-1:0]             one_minus_sat;
  logic [LVL_W+OMS_W-1:0]       p_prod;

  assign r_full        = 32'(s1_hue_q) - 32'(s1_qsec_q) * 32'(SECTOR_SIZE);
  assign q6_prod       = (QS_W+RECIP6_SHIFT)'(s1_qsec_q) * (QS_W+RECIP6_SHIFT)'(RECIP6);
  assign one_minus_sat = OMS_W'(SAT_ONE) - OMS_W'(s1_sat_q);
  assign p_prod        = (LVL_W+OMS_W)'(s1_v_q) * (LVL_W+OMS_W)'(one_minus_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_r_q    <= r_full[SEC_W-1:0];
      s2_qsec_q <= s1_qsec_q;
      s2_q6_q   <= q6_prod[RECIP6_SHIFT +: QS_W];
      s2_sat_q  <= s1_sat_q;
      s2_v_q    <= s1_v_q;
      s2_p_q    <= p_prod[SAT_FRACTION_BITS +: LVL_W];
    end
  end

  // Sector modulo six and the numerators D - r*s and D - (sector size - r)*s.
  logic [QS_W+2:0]   sec_full;
  logic [SEC_W-1:0]  r_rest;
  logic [DEN_W-1:0]  q_sub;
  logic [DEN_W-1:0]  t_sub;

  assign sec_full = (QS_W+3)'(s2_qsec_q) - (QS_W+3)'(s2_q6_q) * (QS_W+3)'(NUM_SECTORS);
  assign r_rest   = SEC_W'(SECTOR_SIZE) - s2_r_q;
  assign q_sub    = DEN_W'(s2_r_q) * DEN_W'(s2_sat_q);
  assign t_sub    = DEN_W'(r_rest) * DEN_W'(s2_sat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_data_q.sector <= sec_full[2:0];
      s3_data_q.v      <= s2_v_q;
      s3_data_q.p      <= s2_p_q;
      s3_data_q.q_num  <= DEN - q_sub;
      s3_data_q.t_num  <= DEN - t_sub;
    end
  end

  assign mid_valid_o = s3_valid_q;
  assign mid_data_o  = s3_data_q;

endmodule

`default_nettype wire

// ===== sv/hsv2rgb_back.sv =====
// Back pipeline of the HSV to RGB converter: scales V by the q and t
// numerators, divides by the denominator, selects channels. Uses hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               mid_valid_i,
  output logic                    mid_ready_o,
  input  wire hsv2rgb_pkg::mid_t  mid_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hsv2rgb_pkg::out_t       out_data_o
);
  import hsv2rgb_pkg::*;

  // Stage 4: full products V * numerator.
  logic               s4_valid_q;
  logic [2:0]         s4_sector_q;
  logic [LVL_W-1:0]   s4_v_q;
  logic [LVL_W-1:0]   s4_p_q;
  logic [PROD_W-1:0]  s4_qprod_q;
  logic [PROD_W-1:0]  s4_tprod_q;
  // Stage 5: output register.
  logic               s5_valid_q;
  out_t               s5_data_q;

  logic s4_ready, s5_ready;

  assign s5_ready    = !s5_valid_q || out_ready_i;
  assign s4_ready    = !s4_valid_q || s5_ready;
  assign mid_ready_o = s4_ready;

  // Products of V with the q and t numerators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && mid_valid_i) begin
      s4_sector_q <= mid_data_i.sector;
      s4_v_q      <= mid_data_i.v;
      s4_p_q      <= mid_data_i.p;
      s4_qprod_q  <= PROD_W'(mid_data_i.v) * PROD_W'(mid_data_i.q_num);
      s4_tprod_q  <= PROD_W'(mid_data_i.v) * PROD_W'(mid_data_i.t_num);
    end
  end

  // The denominator is 15 times a power of two: shift, then divide by 15.
  logic [SH_W-1:0]               q_sh;
  logic [SH_W-1:0]               t_sh;
  logic [SH_W+RECIP15_SHIFT-1:0] q_div;
  logic [SH_W+RECIP15_SHIFT-1:0] t_div;
  logic [LVL_W-1:0]              q_lvl;
  logic [LVL_W-1:0]              t_lvl;

  assign q_sh  = s4_qprod_q[PROD_W-1:DIV_SHIFT];
  assign t_sh  = s4_tprod_q[PROD_W-1:DIV_SHIFT];
  assign q_div = (SH_W+RECIP15_SHIFT)'(q_sh) * (SH_W+RECIP15_SHIFT)'(RECIP15);
  assign t_div = (SH_W+RECIP15_SHIFT)'(t_sh) * (SH_W+RECIP15_SHIFT)'(RECIP15);
  assign q_lvl = q_div[RECIP15_SHIFT +: LVL_W];
  assign t_lvl = t_div[RECIP15_SHIFT +: LVL_W];

  // Channel selection by sector.
  logic [LVL_W-1:0] red, green, blue;

  always_comb begin
    case (s4_sector_q)
      SEC_RED_YELLOW: begin
        red = s4_v_q; green = t_lvl;  blue = s4_p_q;
      end
      SEC_YELLOW_GREEN: begin
        red = q_lvl;  green = s4_v_q; blue = s4_p_q;
      end
      SEC_GREEN_CYAN: begin
        red = s4_p_q; green = s4_v_q; blue = t_lvl;
      end
      SEC_CYAN_BLUE: begin
        red = s4_p_q; green = q_lvl;  blue = s4_v_q;
      end
      SEC_BLUE_MAGENTA: begin
        red = t_lvl;  green = s4_p_q; blue = s4_v_q;
      end
      default: begin
        red = s4_v_q; green = s4_p_q; blue = q_lvl;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (s5_ready) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_valid_q) begin
      s5_data_q.red_level   <= red;
      s5_data_q.green_level <= green;
      s5_data_q.blue_level  <= blue;
      s5_data_q.packed_grb  <= {green, red, blue};
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_data_o  = s5_data_q;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: joins the front and back pipelines.
// Uses hsv2rgb_pkg, hsv2rgb_front and hsv2rgb_back.
//
//   Channel   Signals                              Payload
//   input     in_valid_i / in_ready_o              in_data_i  (hue, sat, value)
//   output    out_valid_o / out_ready_i            out_data_o (r, g, b, grb)
//
// Five register stages, s1 to s5; an accepted request is registered in s1 and
// moves on through s2, s3 and s4 to s5, whose contents drive the output.
// One request can be accepted in every clock cycle unless an output stall fills the pipe.
// Reset clears only the stage valid bits; the data registers need no reset.
// Each stage has its own ready, so a stall at the output holds the filled
// stages and lets empty ones keep taking requests until the pipe is full.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hsv2rgb_pkg::in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hsv2rgb_pkg::out_t       out_data_o
);
  import hsv2rgb_pkg::*;

  logic mid_valid;
  logic mid_ready;
  mid_t mid_data;

  // Sector split, p and numerators.
  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_data_o  (mid_data)
  );

  // Scaling, division and channel selection.
  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_data_i  (mid_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
